// ===== sv/ntp_interleaved_server_stamper_core_defines.svh =====
// Assertion macros for the NTP interleaved server stamper core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef NTP_INTERLEAVED_SERVER_STAMPER_CORE_DEFINES_SVH
`define NTP_INTERLEAVED_SERVER_STAMPER_CORE_DEFINES_SVH

// same-cycle implication
`define NTPIS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntpis assertion failed");

// next-cycle implication
`define NTPIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntpis assertion failed");

`endif

// ===== sv/ntpis_pkg.sv =====
// Shared types, constants and helpers of the NTP interleaved server stamper.
// No dependencies; used by all modules of the block.
package ntpis_pkg;

  localparam int TABLE_DEPTH_DEF   = 1024;
  localparam int MIN_FRAME_LEN_DEF = 90;
  localparam logic [31:0] HASH_MULT = 32'hDE9D_B139;
  localparam int HASH_SHIFT        = 22;
  localparam logic [2:0] MODE_CLIENT = 3'd3;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_SERVE  = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_OFFSET = 2'd1;

  typedef struct packed {
    logic        command;
    logic [31:0] peer_address;
    logic [31:0] dest_address;
    logic [2:0]  packet_mode;
    logic [10:0] frame_length;
    logic [63:0] wire_orig_time;
    logic [63:0] wire_rx_time;
    logic [63:0] wire_tx_time;
    logic [63:0] hw_stamp;
    logic [63:0] now_stamp;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        interleaved;
    logic [63:0] reply_orig_time;
    logic [63:0] reply_rx_time;
    logic [63:0] reply_tx_time;
  } out_item_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  function automatic logic [63:0] swap_bytes(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

endpackage

// ===== sv/ntpis_hash.sv =====
// Client address hash: multiply by a constant, keep the top bits.
// Depends on ntpis_pkg; result registered.
module ntpis_hash #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic [31:0]   peer_address,
  output logic [AW-1:0] cell_idx
);
  import ntpis_pkg::*;

  logic [31:0]   prod;
  logic [31:0]   shifted;
  logic [AW-1:0] cell_idx_r;

  assign prod    = peer_address * HASH_MULT;
  assign shifted = prod >> HASH_SHIFT;

  always_ff @(posedge clk) begin
    cell_idx_r <= shifted[AW-1:0];
  end

  assign cell_idx = cell_idx_r;
endmodule

// ===== sv/ntpis_table_mem.sv =====
// Stamp table: single-port synchronous RAM, {rx stamp, tx stamp} per cell.
// Depends on ntpis_pkg; read data registered.
module ntpis_table_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  ntpis_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]       addr,
  input  logic [127:0]        wdata,
  output logic [127:0]        rdata
);
  import ntpis_pkg::*;

  logic [127:0] mem [DEPTH];
  logic [127:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== sv/ntp_interleaved_server_stamper_core.sv =====
// Top level of the NTP interleaved server stamper: sequencer, filters, reply.
// Depends on ntpis_pkg, ntpis_hash, ntpis_table_mem and the defines header.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------
//   input   | start & !busy         | in_item  (ntpis_pkg::in_item_t)
//   result  | out_valid, one cycle  | out_item (ntpis_pkg::out_item_t)
//   config  | cfg_valid & cfg_ready | cfg_index, cfg_data
//
// A request beat is busy through HASH, MEM and EVAL; its result is registered out
// of EVAL and strobes in the cycle in which the next start can be taken. A record
// beat is busy through HASH and MEM, no result. HASH waits on the hash multiply
// register, EVAL on the table read port. After reset the table is cleared, busy
// high, one cell a cycle. cfg_ready is always high; the result side cannot stall.
`include "ntp_interleaved_server_stamper_core_defines.svh"

module ntp_interleaved_server_stamper_core #(
  parameter int TABLE_DEPTH   = ntpis_pkg::TABLE_DEPTH_DEF,
  parameter int MIN_FRAME_LEN = ntpis_pkg::MIN_FRAME_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  ntpis_pkg::in_item_t                  in_item,
  output logic                                 out_valid,
  output ntpis_pkg::out_item_t                 out_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ntpis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                          cfg_data
);
  import ntpis_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_MEM   = 3'd3;
  localparam logic [2:0] ST_EVAL  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_item_r, out_item_nxt;
  in_item_t      item_r;
  logic [31:0]   own_addr_r;
  logic [63:0]   offset_r;
  logic [63:0]   rx_sum_r, now_sum_r;
  logic          filter_ok_r, xl_pre_r;

  logic [AW-1:0] cell_idx;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [127:0]  mem_wdata, mem_rdata;
  logic          xl;

  ntpis_hash #(.AW(AW)) u_hash (
    .clk          (clk),
    .peer_address (item_r.peer_address),
    .cell_idx     (cell_idx)
  );

  ntpis_table_mem #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign xl = xl_pre_r && (item_r.wire_orig_time == mem_rdata[127:64]);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_ctl       = '0;
    mem_addr      = cell_idx;
    mem_wdata     = {item_r.wire_rx_time, swap_bytes(rx_sum_r)};
    case (state_r)
      ST_CLEAR: begin
        mem_ctl.wr  = 1'b1;
        mem_addr    = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        state_nxt = ST_MEM;
      end
      ST_MEM: begin
        if (item_r.command == CMD_RECORD) begin
          mem_ctl.wr = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          mem_ctl.rd = 1'b1;
          state_nxt  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '0;
        if (filter_ok_r) begin
          out_item_nxt.accepted      = 1'b1;
          out_item_nxt.interleaved   = xl;
          out_item_nxt.reply_rx_time = swap_bytes(rx_sum_r);
          if (xl) begin
            out_item_nxt.reply_orig_time = item_r.wire_rx_time;
            out_item_nxt.reply_tx_time   = mem_rdata[63:0];
          end else begin
            out_item_nxt.reply_orig_time = item_r.wire_tx_time;
            out_item_nxt.reply_tx_time   = swap_bytes(now_sum_r);
          end
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      own_addr_r  <= '0;
      offset_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OWN_ADDRESS: own_addr_r <= cfg_data[31:0];
          CFG_TIME_OFFSET: offset_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (state_r == ST_IDLE && start) begin
      item_r <= in_item;
    end
    if (state_r == ST_HASH) begin
      rx_sum_r    <= item_r.hw_stamp + offset_r;
      now_sum_r   <= item_r.now_stamp + offset_r;
      filter_ok_r <= (item_r.frame_length >= 11'(MIN_FRAME_LEN)) &&
                     (item_r.dest_address == own_addr_r) &&
                     (item_r.peer_address != own_addr_r) &&
                     (item_r.packet_mode == MODE_CLIENT);
      xl_pre_r    <= (item_r.wire_orig_time != 64'd0) &&
                     (item_r.wire_rx_time != item_r.wire_tx_time);
    end
  end

  `NTPIS_ASSERT_NEXT(a_eval_strobes, state_r == ST_EVAL, out_valid && state_r == ST_IDLE)
  `NTPIS_ASSERT_NOW(a_strobe_in_idle, out_valid, state_r == ST_IDLE)
  `NTPIS_ASSERT_NOW(a_clear_busy, state_r == ST_CLEAR, busy && !out_valid)
  `NTPIS_ASSERT_NOW(a_reject_zero, out_valid && !out_item.accepted, out_item.interleaved == 1'b0 && out_item.reply_tx_time == 64'd0 && out_item.reply_rx_time == 64'd0)
  `NTPIS_ASSERT_NEXT(a_record_silent, state_r == ST_MEM && item_r.command == CMD_RECORD, !out_valid)

endmodule
